// File: hdl/ihex_pkg.sv
package ihex_pkg;

  // character codes
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // record type codes
  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_EOF   = 8'h01;
  localparam logic [7:0] TYPE_UPPER = 8'h04;

  // length a valid upper address record carries
  localparam logic [7:0] UPPER_LENGTH = 8'h02;

  // queue between parser and output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    PH_LINE  = 4'd0,
    PH_SKIP  = 4'd1,
    PH_LEN_H = 4'd2,
    PH_LEN_L = 4'd3,
    PH_OFH_H = 4'd4,
    PH_OFH_L = 4'd5,
    PH_OFL_H = 4'd6,
    PH_OFL_L = 4'd7,
    PH_TYP_H = 4'd8,
    PH_TYP_L = 4'd9,
    PH_DAT_H = 4'd10,
    PH_DAT_L = 4'd11,
    PH_SUM_H = 4'd12,
    PH_SUM_L = 4'd13,
    PH_TAIL  = 4'd14
  } phase_t;

  typedef enum logic [3:0] {
    KIND_DATA    = 4'd0,
    KIND_OK      = 4'd1,
    KIND_EOF     = 4'd2,
    KIND_UPPER   = 4'd3,
    KIND_SUMERR  = 4'd4,
    KIND_BADLEN  = 4'd5,
    KIND_UNKNOWN = 4'd6,
    KIND_BADDIG  = 4'd7,
    KIND_SHORT   = 4'd8
  } kind_t;

  // one parsed result on its way to the output side
  typedef struct packed {
    kind_t       kind;
    logic [15:0] upper;
    logic [15:0] offset;
    logic [7:0]  index;
    logic [7:0]  data;
    logic [7:0]  length;
  } event_t;

  // bit 4 set marks a character that is not an uppercase hex digit
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      return {1'b0, diff[3:0]};
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      diff = c - CHAR_UPPER_A;
      return {1'b0, diff[3:0] + 4'd10};
    end
    return 5'b1_0000;
  endfunction

endpackage

// File: hdl/ihex_front.sv
module ihex_front import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] character,
  output logic       ev_valid,
  output event_t     ev
);

  phase_t      phase, phase_next;
  logic [3:0]  first_nibble, first_nibble_next;
  logic [15:0] upper_half, upper_half_next;
  logic [15:0] pending_upper, pending_upper_next;
  logic [7:0]  length_field, length_field_next;
  logic [15:0] offset_field, offset_field_next;
  logic [7:0]  type_field, type_field_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  byte_index, byte_index_next;

  logic [4:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  sum_added;
  logic [7:0]  index_inc;
  logic        is_newline;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LINE;
      first_nibble  <= 4'h0;
      upper_half    <= 16'h0000;
      pending_upper <= 16'h0000;
      length_field  <= 8'h00;
      offset_field  <= 16'h0000;
      type_field    <= 8'h00;
      running_sum   <= 8'h00;
      byte_index    <= 8'h00;
    end else begin
      phase         <= phase_next;
      first_nibble  <= first_nibble_next;
      upper_half    <= upper_half_next;
      pending_upper <= pending_upper_next;
      length_field  <= length_field_next;
      offset_field  <= offset_field_next;
      type_field    <= type_field_next;
      running_sum   <= running_sum_next;
      byte_index    <= byte_index_next;
    end
  end

  assign nib        = nibble_of(character);
  assign byte_val   = {first_nibble, nib[3:0]};
  assign sum_added  = running_sum + byte_val;
  assign index_inc  = byte_index + 8'd1;
  assign is_newline = (character == CHAR_NEWLINE);

  // next state and result
  always_comb begin
    phase_next         = phase;
    first_nibble_next  = first_nibble;
    upper_half_next    = upper_half;
    pending_upper_next = pending_upper;
    length_field_next  = length_field;
    offset_field_next  = offset_field;
    type_field_next    = type_field;
    running_sum_next   = running_sum;
    byte_index_next    = byte_index;

    ev_valid  = 1'b0;
    ev.kind   = KIND_DATA;
    ev.upper  = upper_half;
    ev.offset = offset_field;
    ev.index  = 8'h00;
    ev.data   = 8'h00;
    ev.length = length_field;

    if (accept) begin
      unique case (phase)
        PH_LINE: begin
          if (character == CHAR_COLON) begin
            length_field_next  = 8'h00;
            offset_field_next  = 16'h0000;
            type_field_next    = 8'h00;
            running_sum_next   = 8'h00;
            byte_index_next    = 8'h00;
            pending_upper_next = 16'h0000;
            phase_next         = PH_LEN_H;
          end else if (!is_newline) begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP, PH_TAIL: begin
          if (is_newline) begin
            phase_next = PH_LINE;
          end
        end
        default: begin
          if (is_newline) begin
            phase_next = PH_LINE;
            ev_valid   = 1'b1;
            ev.kind    = KIND_SHORT;
          end else if (nib[4]) begin
            phase_next = PH_SKIP;
            ev_valid   = 1'b1;
            ev.kind    = KIND_BADDIG;
          end else if (!phase[0]) begin
            // high digit of a byte
            first_nibble_next = nib[3:0];
            unique case (phase)
              PH_LEN_H: phase_next = PH_LEN_L;
              PH_OFH_H: phase_next = PH_OFH_L;
              PH_OFL_H: phase_next = PH_OFL_L;
              PH_TYP_H: phase_next = PH_TYP_L;
              PH_DAT_H: phase_next = PH_DAT_L;
              PH_SUM_H: phase_next = PH_SUM_L;
              default:  phase_next = phase;
            endcase
          end else begin
            // low digit completes a byte
            running_sum_next = sum_added;
            unique case (phase)
              PH_LEN_L: begin
                length_field_next = byte_val;
                phase_next        = PH_OFH_H;
              end
              PH_OFH_L: begin
                offset_field_next = {byte_val, offset_field[7:0]};
                phase_next        = PH_OFL_H;
              end
              PH_OFL_L: begin
                offset_field_next = {offset_field[15:8], byte_val};
                phase_next        = PH_TYP_H;
              end
              PH_TYP_L: begin
                type_field_next = byte_val;
                phase_next      = (length_field != 8'h00) ? PH_DAT_H : PH_SUM_H;
              end
              PH_DAT_L: begin
                if (type_field == TYPE_DATA) begin
                  ev_valid = 1'b1;
                  ev.kind  = KIND_DATA;
                  ev.index = byte_index;
                  ev.data  = byte_val;
                end else if (type_field == TYPE_UPPER) begin
                  pending_upper_next = {pending_upper[7:0], byte_val};
                end
                byte_index_next = index_inc;
                phase_next      = (index_inc == length_field) ? PH_SUM_H : PH_DAT_H;
              end
              PH_SUM_L: begin
                ev_valid   = 1'b1;
                phase_next = PH_TAIL;
                if (sum_added != 8'h00) begin
                  ev.kind = KIND_SUMERR;
                end else if (type_field == TYPE_UPPER) begin
                  if (length_field != UPPER_LENGTH) begin
                    ev.kind = KIND_BADLEN;
                  end else begin
                    upper_half_next = pending_upper;
                    ev.kind         = KIND_UPPER;
                  end
                end else if (type_field == TYPE_EOF) begin
                  ev.kind = KIND_EOF;
                end else if (type_field == TYPE_DATA) begin
                  ev.kind = KIND_OK;
                end else begin
                  ev.kind = KIND_UNKNOWN;
                end
              end
              default: phase_next = phase;
            endcase
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/ihex_queue.sv
module ihex_queue import ihex_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_ev,
  output logic   full,
  output logic   head_valid,
  output event_t head,
  input  logic   pop
);

  event_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

endmodule

// File: hdl/ihex_back.sv
module ihex_back import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  event_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [31:0] byte_address,
  output logic [7:0]  data_byte,
  output logic [7:0]  record_length
);

  logic [31:0] addr_sum;

  // output register takes the head when empty or being drained
  assign pop      = head_valid && (!out_valid || !out_stall);
  assign addr_sum = {head.upper, head.offset} + {24'h000000, head.index};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind          <= head.kind;
      byte_address  <= addr_sum;
      data_byte     <= head.data;
      record_length <= head.length;
    end
  end

endmodule

// File: hdl/intel_hex_record_parser.sv
// Intel HEX record parser.
// Input channel: one ASCII character per request (in_valid, in_stall,
// character). A newline (0x0A) ends a line; lines without a leading colon
// are skipped. Output channel: zero or one result per character (out_valid,
// out_stall, kind, byte_address, data_byte, record_length): data bytes of
// type 0 records, one status at each checksum, and bad digit / short line
// reports as they occur.
// Throughput is one character per cycle while the queue is not full. The
// result of a character is written into a four-entry queue at the edge
// that accepts it; the output register takes it from the queue head when
// empty or being drained, and the 32-bit address add is done on that load.
// Reset returns the parser to line start, clears the stored upper address
// half and empties the queue and output register.
// When the receiver stalls, the output result holds; the queue absorbs up
// to four more results and in_stall rises once it is full, so characters
// are held back only while the queue has no room.
module intel_hex_record_parser import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [31:0] byte_address,
  output logic [7:0]  data_byte,
  output logic [7:0]  record_length
);

  logic   accept;
  logic   ev_valid;
  event_t ev;
  logic   q_full;
  logic   head_valid;
  event_t head;
  logic   pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // character parser
  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .character (character),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  // result queue
  ihex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (ev_valid),
    .push_ev    (ev),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // address build and output register
  ihex_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .byte_address  (byte_address),
    .data_byte     (data_byte),
    .record_length (record_length)
  );

endmodule

// File: hdl/ihex_checker.sv
module ihex_checker import ihex_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  kind,
  input logic [31:0] byte_address,
  input logic [7:0]  data_byte,
  input logic [7:0]  record_length
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(kind) && $stable(byte_address) &&
      $stable(data_byte) && $stable(record_length))
    else $error("result payload changed while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // only data results carry a byte
  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'h00)
    else $error("status result carries a data byte");

  // result codes stay within the defined set
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_SHORT)
    else $error("undefined result code");

endmodule

bind intel_hex_record_parser ihex_checker u_checker (.*);
